### rtl/pstm_pkg.sv
// Shared types and constants for the progress slot table with minimum tracker.
package pstm_pkg;

  // Default table depth
  localparam int unsigned SLOT_COUNT_DEF = 256;

  // Field widths fixed by the interface
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER     = 1'b1;

  // Register reset values
  localparam logic [CNT_W-1:0] SLOT_LIMIT_RST = 9'd256;
  localparam logic [VAL_W-1:0] MARKER_RST     = '1;

  typedef enum logic [KIND_W-1:0] {
    K_ACQUIRE = 2'd0,
    K_RELEASE = 2'd1,
    K_UPDATE  = 2'd2,
    K_QUERY   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RETRY   = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // Classified command handed from front to back
  typedef struct packed {
    kind_e             kind;
    logic [ID_W-1:0]   slot_id;
    logic [VAL_W-1:0]  value;
    logic              marker_hit;
  } item_t;

  // Result handed from back to the output ports
  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [ID_W-1:0]   given_slot;
    logic [VAL_W-1:0]  min_value;
    logic [CNT_W-1:0]  live_count;
  } result_t;

endpackage

### rtl/pstm_front.sv
// Front end: classifies commands and holds them in a two-entry queue.
module pstm_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [pstm_pkg::KIND_W-1:0] kind_i,
  input  logic [pstm_pkg::ID_W-1:0]   slot_id_i,
  input  logic [pstm_pkg::VAL_W-1:0]  value_i,
  input  logic [pstm_pkg::VAL_W-1:0]  marker_i,
  output logic                        avail_o,
  output pstm_pkg::item_t             item_o,
  input  logic                        pop_i
);
  import pstm_pkg::*;

  item_t       entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        push;
  logic        pop;
  item_t       item_new;

  // Classify: flag the reserved value up front
  always_comb begin
    item_new.kind       = kind_e'(kind_i);
    item_new.slot_id    = slot_id_i;
    item_new.value      = value_i;
    item_new.marker_hit = (value_i == marker_i);
  end

  assign busy_o  = (count_q == 2'd2);
  assign push    = start_i && !busy_o;
  assign avail_o = (count_q != 2'd0);
  assign pop     = pop_i && avail_o;
  assign item_o  = entry_q[rd_ptr_q];

  // Queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_new;
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/pstm_back.sv
// Back end: slot allocator, recycle stack, value table and minimum scan.
module pstm_back #(
  parameter int unsigned SLOT_COUNT = pstm_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        avail_i,
  input  pstm_pkg::item_t             item_i,
  output logic                        pop_o,
  input  logic [pstm_pkg::CNT_W-1:0]  slot_limit_i,
  input  logic [pstm_pkg::VAL_W-1:0]  marker_i,
  output pstm_pkg::result_t           res_o
);
  import pstm_pkg::*;

  localparam int unsigned IW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned DW  = $clog2(SLOT_COUNT + 1);
  // Slot numbers never reach 256, so valid bits stop there
  localparam int unsigned VW  = (SLOT_COUNT < 256) ? SLOT_COUNT : 256;
  localparam int unsigned VIW = $clog2(VW);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_SCAN} state_e;

  state_e            state_q;
  logic [DW-1:0]     depth_q;
  logic [CNT_W-1:0]  hw_q;
  logic [CNT_W-1:0]  live_q;
  logic [VW-1:0]     valid_q;
  logic [VAL_W-1:0]  cur_val_q;
  logic [CNT_W-1:0]  idx_q;
  logic              rd_pend_q, rd_vbit_q, found_q;
  logic [VAL_W-1:0]  best_q;
  result_t           res_q;

  logic [VAL_W-1:0]  slot_mem [SLOT_COUNT];
  logic [ID_W-1:0]   stk_mem  [SLOT_COUNT];
  logic [VAL_W-1:0]  slot_rdata_q;
  logic [ID_W-1:0]   stk_rdata_q;

  logic              slot_we, stk_we;
  logic [IW-1:0]     slot_waddr, slot_raddr, stk_waddr, stk_raddr;
  logic [VAL_W-1:0]  slot_wdata;

  logic [31:0]       limit;
  logic              table_full, id_bad, stk_full, stk_empty, take;

  // Decode of the head command
  always_comb begin
    limit = (32'(slot_limit_i) < 32'(SLOT_COUNT)) ? 32'(slot_limit_i) : 32'(SLOT_COUNT);
    table_full = (32'(hw_q) >= limit);
    id_bad     = ({1'b0, item_i.slot_id} >= hw_q);
    stk_full   = (32'(depth_q) >= 32'(SLOT_COUNT));
    stk_empty  = (depth_q == '0);
    take       = (state_q == S_IDLE) && avail_i;
  end

  assign pop_o = (state_q == S_IDLE);
  assign res_o = res_q;

  // Memory port control
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = IW'(hw_q);
    slot_wdata = item_i.value;
    slot_raddr = IW'(idx_q);
    stk_we     = 1'b0;
    stk_waddr  = IW'(depth_q);
    stk_raddr  = IW'(depth_q - 1'b1);
    case (state_q)
      S_IDLE: begin
        if (take) begin
          case (item_i.kind)
            K_ACQUIRE: if (!item_i.marker_hit && stk_empty && !table_full) slot_we = 1'b1;
            K_RELEASE: if (!id_bad && !stk_full) stk_we = 1'b1;
            K_UPDATE: begin
              if (!id_bad && !item_i.marker_hit) begin
                slot_we    = 1'b1;
                slot_waddr = IW'(item_i.slot_id);
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        slot_we    = 1'b1;
        slot_waddr = IW'(stk_rdata_q);
        slot_wdata = cur_val_q;
      end
      default: ;
    endcase
  end

  // Value table and recycle stack
  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rdata_q <= slot_mem[slot_raddr];
    if (stk_we) stk_mem[stk_waddr] <= item_i.slot_id;
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  // Command sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      depth_q   <= '0;
      hw_q      <= '0;
      live_q    <= '0;
      valid_q   <= '0;
      cur_val_q <= '0;
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
      rd_vbit_q <= 1'b0;
      found_q   <= 1'b0;
      best_q    <= '0;
      res_q     <= '0;
    end else begin
      res_q.valid <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (take) begin
            res_q.given_slot <= '0;
            res_q.min_value  <= marker_i;
            res_q.live_count <= live_q;
            res_q.status     <= ST_OK;
            case (item_i.kind)
              K_ACQUIRE: begin
                if (item_i.marker_hit) begin
                  res_q.valid  <= 1'b1;
                  res_q.status <= ST_INVALID;
                end else if (stk_empty && table_full) begin
                  res_q.valid  <= 1'b1;
                  res_q.status <= ST_RETRY;
                end else if (!stk_empty) begin
                  // Last freed slot first; stack data arrives next cycle
                  depth_q   <= depth_q - 1'b1;
                  cur_val_q <= item_i.value;
                  state_q   <= S_POP;
                end else begin
                  hw_q                 <= hw_q + 1'b1;
                  valid_q[VIW'(hw_q)]  <= 1'b1;
                  live_q               <= live_q + 1'b1;
                  res_q.valid          <= 1'b1;
                  res_q.given_slot     <= hw_q[ID_W-1:0];
                  res_q.live_count     <= live_q + 1'b1;
                end
              end
              K_RELEASE: begin
                res_q.valid <= 1'b1;
                if (id_bad || stk_full) begin
                  res_q.status <= ST_INVALID;
                end else begin
                  depth_q                      <= depth_q + 1'b1;
                  valid_q[VIW'(item_i.slot_id)] <= 1'b0;
                  live_q                       <= live_q - 1'b1;
                  res_q.live_count             <= live_q - 1'b1;
                end
              end
              K_UPDATE: begin
                res_q.valid <= 1'b1;
                if (id_bad || item_i.marker_hit) begin
                  res_q.status <= ST_INVALID;
                end else begin
                  valid_q[VIW'(item_i.slot_id)] <= 1'b1;
                end
              end
              default: begin
                if (live_q == '0) begin
                  res_q.valid  <= 1'b1;
                  res_q.status <= ST_EMPTY;
                end else begin
                  idx_q     <= '0;
                  rd_pend_q <= 1'b0;
                  found_q   <= 1'b0;
                  state_q   <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_POP: begin
          valid_q[VIW'(stk_rdata_q)] <= 1'b1;
          live_q           <= live_q + 1'b1;
          res_q.valid      <= 1'b1;
          res_q.given_slot <= stk_rdata_q;
          res_q.live_count <= live_q + 1'b1;
          state_q          <= S_IDLE;
        end
        S_SCAN: begin
          // Compare stage on the word read last cycle
          if (rd_pend_q && rd_vbit_q &&
              (!found_q || ($signed(slot_rdata_q) < $signed(best_q)))) begin
            best_q  <= slot_rdata_q;
            found_q <= 1'b1;
          end
          // Read stage walks the used slots
          if (idx_q < hw_q) begin
            rd_pend_q <= 1'b1;
            rd_vbit_q <= valid_q[VIW'(idx_q)];
            idx_q     <= idx_q + 1'b1;
          end else begin
            rd_pend_q <= 1'b0;
            if (!rd_pend_q) begin
              res_q.valid     <= 1'b1;
              res_q.status    <= ST_OK;
              res_q.min_value <= found_q ? best_q : marker_i;
              state_q         <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/progress_slot_table_min_tracker.sv
// Top level: configuration registers, command front end and slot table back end.
//
// Usage: a command (kind_i, slot_id_i, progress_value_i) is taken at a rising
// edge with start high and busy low. Kinds: acquire, release, update and
// query minimum. Every command yields exactly one result, shown for one cycle
// with done_o high on status_o, given_slot_o, min_value_o and live_count_o.
// The receiver cannot stall; results are never held back.
// Commands go through a two-entry queue into a sequencer that handles one at
// a time. An acquire from the recycle stack waits for a stack memory read; a
// query reads the value table one slot per cycle up to high_water. busy is
// high while the queue holds two commands.
// Configuration: cfg_we_i writes register cfg_idx_i (0 slot limit, 1 invalid
// marker) from cfg_wdata_i at the clock edge; the user must write only while
// the block is idle, as the block itself does not enforce it.
// Reset clears the allocator (no slots used, empty stack, no live slots) and
// sets slot limit 256 and marker -1; the table memories need no clearing.
module progress_slot_table_min_tracker #(
  parameter int unsigned SLOT_COUNT = pstm_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [pstm_pkg::KIND_W-1:0]     kind_i,
  input  logic [pstm_pkg::ID_W-1:0]       slot_id_i,
  input  logic signed [pstm_pkg::VAL_W-1:0] progress_value_i,
  input  logic                            cfg_we_i,
  input  logic [pstm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pstm_pkg::VAL_W-1:0]      cfg_wdata_i,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [pstm_pkg::ID_W-1:0]       given_slot_o,
  output logic signed [pstm_pkg::VAL_W-1:0] min_value_o,
  output logic [pstm_pkg::CNT_W-1:0]      live_count_o
);
  import pstm_pkg::*;

  logic [CNT_W-1:0] slot_limit_q;
  logic [VAL_W-1:0] marker_q;
  logic             avail, pop;
  item_t            item;
  result_t          res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_limit_q <= SLOT_LIMIT_RST;
      marker_q     <= MARKER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SLOT_LIMIT: slot_limit_q <= cfg_wdata_i[CNT_W-1:0];
        REG_MARKER:     marker_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pstm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_o    (busy),
    .kind_i    (kind_i),
    .slot_id_i (slot_id_i),
    .value_i   (progress_value_i),
    .marker_i  (marker_q),
    .avail_o   (avail),
    .item_o    (item),
    .pop_i     (pop)
  );

  pstm_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (avail),
    .item_i       (item),
    .pop_o        (pop),
    .slot_limit_i (slot_limit_q),
    .marker_i     (marker_q),
    .res_o        (res)
  );

  assign done_o       = res.valid;
  assign status_o     = res.status;
  assign given_slot_o = res.given_slot;
  assign min_value_o  = res.min_value;
  assign live_count_o = res.live_count;

endmodule

### tb/progress_slot_table_min_tracker_checker.sv
// Checker: predicts slot table results from observed transfers and compares them.
module progress_slot_table_min_tracker_checker
  import pstm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic                    busy,
  input  logic [KIND_W-1:0]       kind_i,
  input  logic [ID_W-1:0]         slot_id_i,
  input  logic [VAL_W-1:0]        progress_value_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [VAL_W-1:0]        cfg_wdata_i,
  input  logic                    done_o,
  input  logic [1:0]              status_o,
  input  logic [ID_W-1:0]         given_slot_o,
  input  logic [VAL_W-1:0]        min_value_o,
  input  logic [CNT_W-1:0]        live_count_o,
  output int                      fail_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_e           status;
    logic [ID_W-1:0]   given;
    logic [VAL_W-1:0]  min_value;
    logic [CNT_W-1:0]  live;
  } slot_answer_t;

  // Shadow copy of the table and allocator
  logic [VAL_W-1:0] table_vals [256];
  logic             table_valid [256];
  logic [ID_W-1:0]  free_stack [256];
  logic [CNT_W-1:0] free_depth;
  logic [CNT_W-1:0] used_mark;
  logic [CNT_W-1:0] live_slots;
  logic [CNT_W-1:0] limit_reg;
  logic [VAL_W-1:0] marker_reg;

  slot_answer_t answers_due [$];
  int           fails;

  assign fail_count_o = fails;
  assign pending_o    = answers_due.size();

  // Apply one command to the shadow state and return its answer
  function automatic slot_answer_t run_command(kind_e kind, logic [ID_W-1:0] id,
                                               logic [VAL_W-1:0] val);
    slot_answer_t     ans;
    logic [CNT_W-1:0] lim;
    logic [ID_W-1:0]  s;
    logic             found;
    ans.status    = ST_OK;
    ans.given     = '0;
    ans.min_value = marker_reg;
    lim = (limit_reg < 9'd256) ? limit_reg : 9'd256;
    case (kind)
      K_ACQUIRE: begin
        if (val == marker_reg) begin
          ans.status = ST_INVALID;
        end else if (free_depth == 0 && used_mark >= lim) begin
          ans.status = ST_RETRY;
        end else begin
          if (free_depth > 0) begin
            free_depth = free_depth - 1'b1;
            s = free_stack[free_depth];
          end else begin
            s = used_mark[ID_W-1:0];
            used_mark = used_mark + 1'b1;
          end
          table_vals[s]  = val;
          table_valid[s] = 1'b1;
          live_slots = live_slots + 1'b1;
          ans.given = s;
        end
      end
      K_RELEASE: begin
        if ({1'b0, id} >= used_mark || free_depth >= 9'd256) begin
          ans.status = ST_INVALID;
        end else begin
          free_stack[free_depth] = id;
          free_depth = free_depth + 1'b1;
          table_valid[id] = 1'b0;
          live_slots = live_slots - 1'b1;
        end
      end
      K_UPDATE: begin
        if ({1'b0, id} >= used_mark || val == marker_reg) begin
          ans.status = ST_INVALID;
        end else begin
          table_vals[id]  = val;
          table_valid[id] = 1'b1;
        end
      end
      default: begin
        if (live_slots == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          found = 1'b0;
          for (int i = 0; i < 256; i++) begin
            if (i < used_mark && table_valid[i] &&
                (!found || $signed(table_vals[i]) < $signed(ans.min_value))) begin
              ans.min_value = table_vals[i];
              found = 1'b1;
            end
          end
        end
      end
    endcase
    ans.live = live_slots;
    return ans;
  endfunction

  // Track transfers, config writes and results
  always @(posedge clk_i or negedge rst_ni) begin
    slot_answer_t want;
    if (!rst_ni) begin
      free_depth = '0;
      used_mark  = '0;
      live_slots = '0;
      limit_reg  = SLOT_LIMIT_RST;
      marker_reg = MARKER_RST;
      for (int i = 0; i < 256; i++) table_valid[i] = 1'b0;
      fails = 0;
    end else begin
      if (done_o) begin
        if (answers_due.size() == 0) begin
          $error("result with nothing expected");
          fails++;
        end else begin
          want = answers_due.pop_front();
          if (status_o != want.status) begin
            $error("status: expected %0d actual %0d", want.status, status_o);
            fails++;
          end
          if (given_slot_o != want.given) begin
            $error("given_slot: expected %0d actual %0d", want.given, given_slot_o);
            fails++;
          end
          if (min_value_o != want.min_value) begin
            $error("min_value: expected %0d actual %0d",
                   $signed(want.min_value), $signed(min_value_o));
            fails++;
          end
          if (live_count_o != want.live) begin
            $error("live_count: expected %0d actual %0d", want.live, live_count_o);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        want = run_command(kind_e'(kind_i), slot_id_i, progress_value_i);
        answers_due.insert(answers_due.size(), want);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SLOT_LIMIT) limit_reg = cfg_wdata_i[CNT_W-1:0];
        else marker_reg = cfg_wdata_i;
      end
    end
  end
endmodule

### tb/progress_slot_table_min_tracker_test.sv
// Testbench top: drives commands and config writes, and reports the verdict.
module progress_slot_table_min_tracker_test;
  import pstm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [KIND_W-1:0]      kind_i = '0;
  logic [ID_W-1:0]        slot_id_i = '0;
  logic [VAL_W-1:0]       progress_value_i = '0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [VAL_W-1:0]       cfg_wdata_i = '0;
  logic                   done_o;
  logic [1:0]             status_o;
  logic [ID_W-1:0]        given_slot_o;
  logic [VAL_W-1:0]       min_value_o;
  logic [CNT_W-1:0]       live_count_o;
  int                     fail_count;
  int                     pending;
  logic [VAL_W-1:0]       cur_marker = MARKER_RST;
  int                     burst_left = 0;
  int                     quiet_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  progress_slot_table_min_tracker dut (.*);

  progress_slot_table_min_tracker_checker checker_u (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .slot_id_i, .progress_value_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .done_o, .status_o, .given_slot_o,
    .min_value_o, .live_count_o, .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog on cycles with no transfer, no config write and no result
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_we_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One command transfer, with bursty gaps after it
  task automatic send_cmd(kind_e kind, logic [ID_W-1:0] id, logic [VAL_W-1:0] val);
    int gap;
    @(negedge clk_i);
    kind_i <= kind;
    slot_id_i <= id;
    progress_value_i <= val;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // Drain all results, then write both registers
  task automatic drain_and_config(logic [CNT_W-1:0] limit, logic [VAL_W-1:0] marker);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_SLOT_LIMIT;
    cfg_wdata_i <= {55'd0, limit};
    @(negedge clk_i);
    cfg_idx_i <= REG_MARKER;
    cfg_wdata_i <= marker;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_marker = marker;
  endtask

  task automatic random_cmd();
    int r;
    kind_e k;
    logic [ID_W-1:0] id;
    logic [VAL_W-1:0] v;
    r = $urandom_range(0, 99);
    k = (r < 35) ? K_ACQUIRE : (r < 60) ? K_RELEASE : (r < 80) ? K_UPDATE : K_QUERY;
    id = ($urandom_range(0, 9) < 8) ? ID_W'($urandom_range(0, 15)) : ID_W'($urandom);
    r = $urandom_range(0, 9);
    if (r == 0) v = cur_marker;
    else if (r < 3) v = VAL_W'($signed($urandom_range(0, 40)) - 20);
    else v = {$urandom, $urandom};
    send_cmd(k, id, v);
  endtask

  initial begin
    logic [CNT_W-1:0] limits [7] = '{9'd256, 9'd5, 9'd1, 9'd0, 9'd300, 9'd16, 9'd511};
    logic [VAL_W-1:0] markers [7];
    markers = '{64'd0, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 64'd7,
                64'hffff_ffff_ffff_ffff, 64'd3, 64'h1234_5678_9abc_def0};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty query, marker rejection, extremes, bad ids, double release
    send_cmd(K_QUERY, 8'd0, 64'd0);
    send_cmd(K_ACQUIRE, 8'd0, MARKER_RST);
    send_cmd(K_ACQUIRE, 8'd0, 64'h7fff_ffff_ffff_ffff);
    send_cmd(K_ACQUIRE, 8'd0, 64'h8000_0000_0000_0000);
    send_cmd(K_QUERY, 8'd0, 64'd0);
    send_cmd(K_UPDATE, 8'd1, 64'd0);
    send_cmd(K_UPDATE, 8'd200, 64'd9);
    send_cmd(K_UPDATE, 8'd0, MARKER_RST);
    send_cmd(K_QUERY, 8'd0, 64'd0);
    send_cmd(K_RELEASE, 8'd0, 64'd0);
    send_cmd(K_RELEASE, 8'd0, 64'd0);
    send_cmd(K_RELEASE, 8'd5, 64'd0);
    send_cmd(K_RELEASE, 8'd255, 64'd0);
    send_cmd(K_UPDATE, 8'd0, 64'd42);
    send_cmd(K_QUERY, 8'd0, 64'd0);
    send_cmd(K_ACQUIRE, 8'd0, 64'd11);
    send_cmd(K_RELEASE, 8'd1, 64'd0);
    send_cmd(K_RELEASE, 8'd0, 64'd0);
    send_cmd(K_QUERY, 8'd0, 64'd0);

    // Random phases over several register settings
    for (int p = 0; p < 7; p++) begin
      drain_and_config(limits[p], markers[p]);
      if (limits[p] == 9'd0) begin
        repeat (40) send_cmd(K_ACQUIRE, 8'd0, 64'd1);
        send_cmd(K_ACQUIRE, 8'd0, 64'd1);
      end
      repeat (45) random_cmd();
    end

    // Full recycle stack by repeated release, then pop a few
    drain_and_config(9'd256, MARKER_RST);
    send_cmd(K_ACQUIRE, 8'd0, 64'd5);
    repeat (260) send_cmd(K_RELEASE, 8'd0, 64'd0);
    send_cmd(K_QUERY, 8'd0, 64'd0);
    repeat (3) send_cmd(K_ACQUIRE, 8'd0, {$urandom, $urandom});

    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
